>>> design/gmds_pkg.sv
// Shared types and constants for the grid maze depth-first solver.
// Used by gmds_ram and grid_maze_dfs_solver_core; depends on nothing.
`timescale 1ns / 1ps

package gmds_pkg;

    // Default storage size of the grid
    localparam int DEF_MAX_ROWS = 64;
    localparam int DEF_MAX_COLS = 64;

    // Cell marks
    localparam int         MARK_W       = 2;
    localparam logic [1:0] MARK_OPEN    = 2'd0;
    localparam logic [1:0] MARK_BLOCKED = 2'd1;
    localparam logic [1:0] MARK_PATH    = 2'd2;
    localparam logic [1:0] MARK_DEAD    = 2'd3;

    // Operation codes carried in s_tuser
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_SOLVE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // Search directions, in the order they are tried
    localparam logic [1:0] DIR_RIGHT = 2'd0;
    localparam logic [1:0] DIR_DOWN  = 2'd1;
    localparam logic [1:0] DIR_LEFT  = 2'd2;
    localparam logic [1:0] DIR_UP    = 2'd3;

    // Configuration registers
    localparam int         DIM_REG_W = 7;
    localparam logic [6:0] DIM_RESET = 7'd64;
    localparam logic       REG_ROWS  = 1'b0;
    localparam logic       REG_COLS  = 1'b1;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_INIT,
        ST_PROBE,
        ST_CHECK,
        ST_POP,
        ST_DONE
    } state_t;

endpackage

>>> design/gmds_ram.sv
// Simple dual-port synchronous RAM: one write port, one registered read port.
// Depends on gmds_pkg for the default word width.
`timescale 1ns / 1ps

module gmds_ram #(
    parameter int WIDTH = gmds_pkg::MARK_W,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, registered
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> design/grid_maze_dfs_solver_core.sv
// Top level of the grid maze depth-first solver: stream ports, APB registers,
// search sequencer. Depends on gmds_pkg and gmds_ram (grid marks and move stack).
`timescale 1ns / 1ps

// Usage
//   Input stream s_*: one transfer per command. s_tuser carries the op (write cell,
//   solve, read mark); s_tdata carries row, column and the blocked flag.
//   Output stream m_*: exactly one transfer per command, in command order:
//   m_tdata[0] solved (solve only), m_tdata[2:1] cell mark (read only), else zero.
//   APB port: grid_rows at 0x0, grid_cols at 0x4; write them only while idle.
// Sequencing
//   Write: the command goes from idle to ST_DONE, which loads the output register;
//   a read passes through ST_READ on the way. The next command is taken from idle.
//   Solve: the sequencer makes at most one mark RAM access per cycle; each direction
//   tried passes through ST_PROBE, and also ST_CHECK when the neighbour's mark has to
//   be fetched, and each back-step passes through ST_PROBE and ST_POP. Commands are
//   processed one at a time.
// Reset
//   Registers return to 64 x 64 and the sequencer to idle. The mark and stack
//   RAMs are not cleared; every cell must be written before it is read or searched.
// Stall
//   A finished result waits in the output register; the next command is taken
//   meanwhile and holds in its final state until the register is free.

module grid_maze_dfs_solver_core #(
    parameter int MAX_ROWS = gmds_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = gmds_pkg::DEF_MAX_COLS
) (
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [5:0] cell_row, [11:6] cell_col, [12] cell_blocked
    input  logic [1:0]  s_tuser,   // [1:0] op
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [0] solved, [2:1] cell_mark
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CELLS   = MAX_ROWS * MAX_COLS;
    localparam int ROW_W   = $clog2(MAX_ROWS);
    localparam int COL_W   = $clog2(MAX_COLS);
    localparam int ADDR_W  = $clog2(CELLS);
    localparam int DEPTH_W = $clog2(CELLS + 1);
    localparam int DIM_R   = ROW_W + 1;
    localparam int DIM_C   = COL_W + 1;
    // widths to compare register and input values against the storage size
    localparam int RCMP_W  = (DIM_R > gmds_pkg::DIM_REG_W) ? DIM_R : gmds_pkg::DIM_REG_W;
    localparam int CCMP_W  = (DIM_C > gmds_pkg::DIM_REG_W) ? DIM_C : gmds_pkg::DIM_REG_W;
    localparam int IRW     = (DIM_R > 6) ? DIM_R : 6;
    localparam int ICW     = (DIM_C > 6) ? DIM_C : 6;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                     input logic [COL_W-1:0] c);
        cell_addr = ADDR_W'(r) * ADDR_W'(MAX_COLS) + ADDR_W'(c);
    endfunction

    gmds_pkg::state_t state_reg, state_next;

    logic [gmds_pkg::DIM_REG_W-1:0] grid_rows_reg, grid_cols_reg;
    logic [ROW_W-1:0]   cur_row_reg, cur_row_next;
    logic [COL_W-1:0]   cur_col_reg, cur_col_next;
    logic [2:0]         dir_reg, dir_next;
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    logic               inside_reg, inside_next;
    logic               res_solved_reg, res_solved_next;
    logic [1:0]         res_mark_reg, res_mark_next;
    logic               m_valid_reg, m_valid_next;
    logic               m_solved_reg, m_solved_next;
    logic [1:0]         m_mark_reg, m_mark_next;

    // RAM ports
    logic              g_we, g_re, k_we, k_re;
    logic [ADDR_W-1:0] g_waddr, g_raddr, k_waddr, k_raddr;
    logic [1:0]        g_wdata, g_rdata, k_wdata, k_rdata;

    // Derived values
    logic [DIM_R-1:0]   rows_eff;
    logic [DIM_C-1:0]   cols_eff;
    logic [IRW-1:0]     in_row_ext;
    logic [ICW-1:0]     in_col_ext;
    logic               in_inside;
    logic [ADDR_W-1:0]  in_addr, cur_addr, nb_addr;
    logic [ROW_W-1:0]   nb_row, back_row;
    logic [COL_W-1:0]   nb_col, back_col;
    logic               nb_ok, nb_goal;
    logic [DEPTH_W-1:0] depth_dec;

    // Effective grid size: zero acts as one, clamp to storage
    always_comb
    begin
        logic [RCMP_W-1:0] r;
        logic [CCMP_W-1:0] c;
        r = RCMP_W'(grid_rows_reg);
        c = CCMP_W'(grid_cols_reg);
        if (r == '0)
            r = RCMP_W'(1);
        else if (r > RCMP_W'(MAX_ROWS))
            r = RCMP_W'(MAX_ROWS);
        if (c == '0)
            c = CCMP_W'(1);
        else if (c > CCMP_W'(MAX_COLS))
            c = CCMP_W'(MAX_COLS);
        rows_eff = r[DIM_R-1:0];
        cols_eff = c[DIM_C-1:0];
    end

    // Input cell address and storage range check
    assign in_row_ext = IRW'(s_tdata[5:0]);
    assign in_col_ext = ICW'(s_tdata[11:6]);
    assign in_inside  = (in_row_ext < IRW'(MAX_ROWS)) && (in_col_ext < ICW'(MAX_COLS));
    assign in_addr    = cell_addr(in_row_ext[ROW_W-1:0], in_col_ext[COL_W-1:0]);
    assign cur_addr   = cell_addr(cur_row_reg, cur_col_reg);
    assign nb_addr    = cell_addr(nb_row, nb_col);
    assign depth_dec  = depth_reg - 1'b1;

    // Neighbour in the current direction, valid only inside the rows and columns in use
    always_comb
    begin
        nb_row = cur_row_reg;
        nb_col = cur_col_reg;
        nb_ok  = 1'b0;
        case (dir_reg[1:0])
            gmds_pkg::DIR_RIGHT:
            begin
                nb_col = cur_col_reg + 1'b1;
                nb_ok  = ({1'b0, cur_col_reg} + 1'b1) < cols_eff;
            end
            gmds_pkg::DIR_DOWN:
            begin
                nb_row = cur_row_reg + 1'b1;
                nb_ok  = ({1'b0, cur_row_reg} + 1'b1) < rows_eff;
            end
            gmds_pkg::DIR_LEFT:
            begin
                nb_col = cur_col_reg - 1'b1;
                nb_ok  = cur_col_reg != '0;
            end
            default:
            begin
                nb_row = cur_row_reg - 1'b1;
                nb_ok  = cur_row_reg != '0;
            end
        endcase
        nb_goal = (({1'b0, nb_row} + 1'b1) == rows_eff) &&
                  (({1'b0, nb_col} + 1'b1) == cols_eff);
    end

    // Step back against the popped direction
    always_comb
    begin
        back_row = cur_row_reg;
        back_col = cur_col_reg;
        case (k_rdata)
            gmds_pkg::DIR_RIGHT: back_col = cur_col_reg - 1'b1;
            gmds_pkg::DIR_DOWN:  back_row = cur_row_reg - 1'b1;
            gmds_pkg::DIR_LEFT:  back_col = cur_col_reg + 1'b1;
            default:             back_row = cur_row_reg + 1'b1;
        endcase
    end

    assign s_tready = (state_reg == gmds_pkg::ST_IDLE);

    // Sequencer. Within each RAM, every write and every read issue fall on different edges,
    // so a read never meets a write to the same cell in flight.
    always_comb
    begin
        state_next      = state_reg;
        cur_row_next    = cur_row_reg;
        cur_col_next    = cur_col_reg;
        dir_next        = dir_reg;
        depth_next      = depth_reg;
        inside_next     = inside_reg;
        res_solved_next = res_solved_reg;
        res_mark_next   = res_mark_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_solved_next   = m_solved_reg;
        m_mark_next     = m_mark_reg;
        g_we    = 1'b0;
        g_waddr = cur_addr;
        g_wdata = gmds_pkg::MARK_PATH;
        g_re    = 1'b0;
        g_raddr = nb_addr;
        k_we    = 1'b0;
        k_waddr = depth_reg[ADDR_W-1:0];
        k_wdata = dir_reg[1:0];
        k_re    = 1'b0;
        k_raddr = depth_dec[ADDR_W-1:0];

        unique case (state_reg)
            gmds_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    res_solved_next = 1'b0;
                    res_mark_next   = gmds_pkg::MARK_OPEN;
                    inside_next     = in_inside;
                    case (s_tuser)
                        gmds_pkg::OP_WRITE:
                        begin
                            g_we       = in_inside;
                            g_waddr    = in_addr;
                            g_wdata    = s_tdata[12] ? gmds_pkg::MARK_BLOCKED
                                                     : gmds_pkg::MARK_OPEN;
                            state_next = gmds_pkg::ST_DONE;
                        end
                        gmds_pkg::OP_SOLVE:
                        begin
                            state_next = gmds_pkg::ST_INIT;
                        end
                        gmds_pkg::OP_READ:
                        begin
                            g_re       = in_inside;
                            g_raddr    = in_addr;
                            state_next = gmds_pkg::ST_READ;
                        end
                        default:
                        begin
                            state_next = gmds_pkg::ST_DONE;
                        end
                    endcase
                end
            end

            gmds_pkg::ST_READ:
            begin
                res_mark_next = inside_reg ? g_rdata : gmds_pkg::MARK_BLOCKED;
                state_next    = gmds_pkg::ST_DONE;
            end

            // start cell is entered unconditionally
            gmds_pkg::ST_INIT:
            begin
                g_we         = 1'b1;
                g_waddr      = '0;
                cur_row_next = '0;
                cur_col_next = '0;
                dir_next     = '0;
                depth_next   = '0;
                if (rows_eff == DIM_R'(1) && cols_eff == DIM_C'(1))
                begin
                    res_solved_next = 1'b1;
                    state_next      = gmds_pkg::ST_DONE;
                end
                else
                begin
                    state_next = gmds_pkg::ST_PROBE;
                end
            end

            gmds_pkg::ST_PROBE:
            begin
                if (dir_reg[2])
                begin
                    // all directions tried: dead end, back up
                    g_we    = 1'b1;
                    g_waddr = cur_addr;
                    g_wdata = gmds_pkg::MARK_DEAD;
                    if (depth_reg == '0)
                    begin
                        state_next = gmds_pkg::ST_DONE;
                    end
                    else
                    begin
                        k_re       = 1'b1;
                        depth_next = depth_dec;
                        state_next = gmds_pkg::ST_POP;
                    end
                end
                else if (nb_ok)
                begin
                    g_re       = 1'b1;
                    state_next = gmds_pkg::ST_CHECK;
                end
                else
                begin
                    dir_next = dir_reg + 1'b1;
                end
            end

            gmds_pkg::ST_CHECK:
            begin
                if (g_rdata == gmds_pkg::MARK_OPEN && depth_reg < DEPTH_W'(CELLS))
                begin
                    // enter the neighbour
                    k_we         = 1'b1;
                    g_we         = 1'b1;
                    g_waddr      = nb_addr;
                    depth_next   = depth_reg + 1'b1;
                    cur_row_next = nb_row;
                    cur_col_next = nb_col;
                    dir_next     = '0;
                    if (nb_goal)
                    begin
                        res_solved_next = 1'b1;
                        state_next      = gmds_pkg::ST_DONE;
                    end
                    else
                    begin
                        state_next = gmds_pkg::ST_PROBE;
                    end
                end
                else
                begin
                    dir_next   = dir_reg + 1'b1;
                    state_next = gmds_pkg::ST_PROBE;
                end
            end

            gmds_pkg::ST_POP:
            begin
                cur_row_next = back_row;
                cur_col_next = back_col;
                dir_next     = {1'b0, k_rdata} + 1'b1;
                state_next   = gmds_pkg::ST_PROBE;
            end

            gmds_pkg::ST_DONE:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next  = 1'b1;
                    m_solved_next = res_solved_reg;
                    m_mark_next   = res_mark_reg;
                    state_next    = gmds_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = gmds_pkg::ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gmds_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Search and output registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_row_reg    <= '0;
            cur_col_reg    <= '0;
            dir_reg        <= '0;
            depth_reg      <= '0;
            inside_reg     <= 1'b0;
            res_solved_reg <= 1'b0;
            res_mark_reg   <= '0;
            m_valid_reg    <= 1'b0;
            m_solved_reg   <= 1'b0;
            m_mark_reg     <= '0;
        end
        else
        begin
            cur_row_reg    <= cur_row_next;
            cur_col_reg    <= cur_col_next;
            dir_reg        <= dir_next;
            depth_reg      <= depth_next;
            inside_reg     <= inside_next;
            res_solved_reg <= res_solved_next;
            res_mark_reg   <= res_mark_next;
            m_valid_reg    <= m_valid_next;
            m_solved_reg   <= m_solved_next;
            m_mark_reg     <= m_mark_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b0, m_mark_reg, m_solved_reg};

    // APB registers
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_rows_reg <= gmds_pkg::DIM_RESET;
            grid_cols_reg <= gmds_pkg::DIM_RESET;
        end
        else if (psel && penable && pwrite && pready)
        begin
            unique case (paddr[2])
                gmds_pkg::REG_ROWS: grid_rows_reg <= pwdata[gmds_pkg::DIM_REG_W-1:0];
                gmds_pkg::REG_COLS: grid_cols_reg <= pwdata[gmds_pkg::DIM_REG_W-1:0];
                default:            grid_rows_reg <= grid_rows_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            gmds_pkg::REG_ROWS: prdata = 32'(grid_rows_reg);
            gmds_pkg::REG_COLS: prdata = 32'(grid_cols_reg);
            default:            prdata = '0;
        endcase
    end

    // Cell marks
    gmds_ram #(
        .WIDTH (gmds_pkg::MARK_W),
        .DEPTH (CELLS)
    ) u_marks (
        .clk   (clk),
        .we    (g_we),
        .waddr (g_waddr),
        .wdata (g_wdata),
        .re    (g_re),
        .raddr (g_raddr),
        .rdata (g_rdata)
    );

    // Move stack: one direction per search level
    gmds_ram #(
        .WIDTH (gmds_pkg::MARK_W),
        .DEPTH (CELLS)
    ) u_stack (
        .clk   (clk),
        .we    (k_we),
        .waddr (k_waddr),
        .wdata (k_wdata),
        .re    (k_re),
        .raddr (k_raddr),
        .rdata (k_rdata)
    );

endmodule
